/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// cond holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
// cons holds in the same cycle as ante
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// cons holds in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* sv/mtd_pkg.sv */
// ----------------------------------------------------------------------------
// mtd_pkg
// Types, character codes and decode helpers for the MIME transfer decoder.
// ----------------------------------------------------------------------------
package mtd_pkg;

  // decode modes
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_QP   = 2'd1;
  localparam logic [1:0] MODE_B64  = 2'd2;
  localparam int         B64_SEL_BIT = 1;

  // item commands
  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // character codes
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_EQ  = 8'h3d;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;

  localparam int MAX_RESULTS   = 4;
  localparam int QUEUE_DEPTH   = 4;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // all bytes produced by one input item
  typedef struct packed {
    logic [2:0]                   cnt;
    logic [MAX_RESULTS-1:0][7:0]  bytes;
  } bundle_t;

  typedef struct packed {
    bundle_t bund;
    logic    cr;
  } dec_out_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } b64_val_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_val_t;

  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_EQ,
    ESC_HEX
  } esc_t;

  // base64 alphabet lookup, '=' maps to zero
  function automatic b64_val_t b64_decode(input logic [7:0] c);
    b64_val_t r;
    r.ok  = 1'b1;
    r.val = 6'd0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r.val = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2b) begin
      r.val = 6'd62;
    end else if (c == 8'h2f) begin
      r.val = 6'd63;
    end else if (c != CH_EQ) begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // hex digit lookup, either case
  function automatic hex_val_t hex_decode(input logic [7:0] c);
    hex_val_t r;
    r.ok  = 1'b1;
    r.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.val = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.val = 4'(c - 8'h61 + 8'd10);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // pass up to three decoded bytes through the CR-before-LF filter
  function automatic dec_out_t put_seq(input logic [1:0] n, input logic [2:0][7:0] d,
                                       input logic cr_in);
    dec_out_t   r;
    logic       cr;
    logic [2:0] k;
    r  = '0;
    cr = cr_in;
    k  = 3'd0;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < n) begin
        if (cr && d[i] == CH_LF) begin
          r.bund.bytes[k[1:0]] = CH_LF;
          k  = k + 3'd1;
          cr = 1'b0;
        end else begin
          if (cr) begin
            r.bund.bytes[k[1:0]] = CH_CR;
            k = k + 3'd1;
          end
          cr = (d[i] == CH_CR);
          if (d[i] != CH_CR) begin
            r.bund.bytes[k[1:0]] = d[i];
            k = k + 3'd1;
          end
        end
      end
    end
    r.bund.cnt = k;
    r.cr       = cr;
    return r;
  endfunction

endpackage

/* sv/mtd_front.sv */
// ----------------------------------------------------------------------------
// mtd_front
// Accepts input items, runs the base64 / quoted-printable decode state and
// pushes the bytes of each item as one bundle into the queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mtd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  mtd_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output mtd_pkg::bundle_t  q_data
);

  logic [1:0]    mode_r;
  logic [1:0]    gc_r, gc_nxt;
  logic [17:0]   bits_r, bits_nxt;
  logic          twp_r, twp_nxt;
  logic          gap_r, gap_nxt;
  logic          skip_r, skip_nxt;
  mtd_pkg::esc_t esc_r, esc_nxt;
  logic [7:0]    held_r, held_nxt;
  logic          cr_r, cr_nxt;

  logic               in_acc;
  logic [7:0]         c;
  logic               pad;
  logic               is_qp;
  logic               is_b64;
  logic [23:0]        word;
  mtd_pkg::b64_val_t  bv;
  mtd_pkg::hex_val_t  hx;
  mtd_pkg::hex_val_t  hh;
  logic [1:0]         dn;
  logic [2:0][7:0]    d;
  mtd_pkg::dec_out_t  res;
  mtd_pkg::bundle_t   bund;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign in_acc    = in_valid && in_ready;
  assign c         = in_data.in_byte;
  assign pad       = (c == mtd_pkg::CH_EQ);
  assign is_b64    = mode_r[mtd_pkg::B64_SEL_BIT];
  assign is_qp     = (mode_r == mtd_pkg::MODE_QP);
  assign bv        = mtd_pkg::b64_decode(c);
  assign hx        = mtd_pkg::hex_decode(c);
  assign hh        = mtd_pkg::hex_decode(held_r);
  assign word      = {bits_r, bv.val};

  // hold the mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= mtd_pkg::MODE_NONE;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data;
    end
  end

  // next escape stage
  always_comb begin
    esc_nxt = esc_r;
    if (in_data.cmd == mtd_pkg::CMD_FLUSH) begin
      esc_nxt = mtd_pkg::ESC_IDLE;
    end else if (!is_b64 && is_qp) begin
      case (esc_r)
        mtd_pkg::ESC_IDLE: begin
          esc_nxt = pad ? mtd_pkg::ESC_EQ : mtd_pkg::ESC_IDLE;
        end
        mtd_pkg::ESC_EQ: begin
          if (hx.ok) begin
            esc_nxt = mtd_pkg::ESC_HEX;
          end else begin
            esc_nxt = pad ? mtd_pkg::ESC_EQ : mtd_pkg::ESC_IDLE;
          end
        end
        mtd_pkg::ESC_HEX: begin
          if (hx.ok) begin
            esc_nxt = mtd_pkg::ESC_IDLE;
          end else begin
            esc_nxt = pad ? mtd_pkg::ESC_EQ : mtd_pkg::ESC_IDLE;
          end
        end
        default: begin
          esc_nxt = mtd_pkg::ESC_IDLE;
        end
      endcase
    end
  end

  // decode one item: group state, decoded bytes, CR filter
  always_comb begin
    gc_nxt   = gc_r;
    bits_nxt = bits_r;
    twp_nxt  = twp_r;
    gap_nxt  = gap_r;
    skip_nxt = skip_r;
    held_nxt = held_r;
    dn       = 2'd0;
    d        = '0;
    if (in_data.cmd == mtd_pkg::CMD_FLUSH) begin
      // release a held escape, drop the open group
      case (esc_r)
        mtd_pkg::ESC_EQ: begin
          d[0] = mtd_pkg::CH_EQ;
          dn   = 2'd1;
        end
        mtd_pkg::ESC_HEX: begin
          d[0] = mtd_pkg::CH_EQ;
          d[1] = held_r;
          dn   = 2'd2;
        end
        default: begin
          dn = 2'd0;
        end
      endcase
      gc_nxt   = 2'd0;
      bits_nxt = '0;
      twp_nxt  = 1'b0;
      gap_nxt  = 1'b1;
      skip_nxt = 1'b0;
    end else if (is_b64) begin
      if (c == mtd_pkg::CH_LF) begin
        gc_nxt   = 2'd0;
        bits_nxt = '0;
        twp_nxt  = 1'b0;
        gap_nxt  = 1'b1;
        skip_nxt = 1'b0;
      end else if (skip_r) begin
        skip_nxt = 1'b1;
      end else if (gc_r == 2'd0 && (c == mtd_pkg::CH_SP || c == mtd_pkg::CH_TAB)) begin
        gc_nxt = 2'd0;
      end else if (!bv.ok || (gc_r == 2'd3 && gap_r && pad)) begin
        // invalid character or all-pad group: drop the rest of the line
        gc_nxt   = 2'd0;
        bits_nxt = '0;
        twp_nxt  = 1'b0;
        gap_nxt  = 1'b1;
        skip_nxt = 1'b1;
      end else if (gc_r != 2'd3) begin
        bits_nxt = {bits_r[11:0], bv.val};
        if (gc_r == 2'd2) begin
          twp_nxt = pad;
        end
        gap_nxt = gap_r & pad;
        gc_nxt  = gc_r + 2'd1;
      end else begin
        // complete the group
        d[0] = word[23:16];
        d[1] = word[15:8];
        d[2] = word[7:0];
        dn   = twp_r ? 2'd1 : (pad ? 2'd2 : 2'd3);
        gc_nxt   = 2'd0;
        bits_nxt = '0;
        twp_nxt  = 1'b0;
        gap_nxt  = 1'b1;
      end
    end else if (is_qp) begin
      case (esc_r)
        mtd_pkg::ESC_IDLE: begin
          if (!pad) begin
            d[0] = c;
            dn   = 2'd1;
          end
        end
        mtd_pkg::ESC_EQ: begin
          if (hx.ok) begin
            held_nxt = c;
          end else if (c != mtd_pkg::CH_LF) begin
            d[0] = mtd_pkg::CH_EQ;
            d[1] = c;
            dn   = pad ? 2'd1 : 2'd2;
          end
        end
        mtd_pkg::ESC_HEX: begin
          if (hx.ok) begin
            d[0] = {hh.val, hx.val};
            dn   = 2'd1;
          end else begin
            d[0] = mtd_pkg::CH_EQ;
            d[1] = held_r;
            d[2] = c;
            dn   = pad ? 2'd2 : 2'd3;
          end
        end
        default: begin
          dn = 2'd0;
        end
      endcase
    end else begin
      d[0] = c;
      dn   = 2'd1;
    end

    res  = mtd_pkg::put_seq(dn, d, cr_r);
    bund = res.bund;
    cr_nxt = res.cr;
    // a flush releases a pending CR as is
    if (in_data.cmd == mtd_pkg::CMD_FLUSH && res.cr) begin
      bund.bytes[bund.cnt[1:0]] = mtd_pkg::CH_CR;
      bund.cnt = bund.cnt + 3'd1;
      cr_nxt   = 1'b0;
    end
  end

  assign q_push = in_acc && (bund.cnt != 3'd0);
  assign q_data = bund;

  // advance decode state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gc_r   <= 2'd0;
      bits_r <= '0;
      twp_r  <= 1'b0;
      gap_r  <= 1'b1;
      skip_r <= 1'b0;
      esc_r  <= mtd_pkg::ESC_IDLE;
      held_r <= '0;
      cr_r   <= 1'b0;
    end else if (in_acc) begin
      gc_r   <= gc_nxt;
      bits_r <= bits_nxt;
      twp_r  <= twp_nxt;
      gap_r  <= gap_nxt;
      skip_r <= skip_nxt;
      esc_r  <= esc_nxt;
      held_r <= held_nxt;
      cr_r   <= cr_nxt;
    end
  end

  `ASSERT_NEXT(a_flush_clears, clk, rst_n, in_acc && in_data.cmd == mtd_pkg::CMD_FLUSH, esc_r == mtd_pkg::ESC_IDLE && !cr_r && gc_r == 2'd0 && !skip_r)
  `ASSERT_IMPLIES(a_bundle_bound, clk, rst_n, q_push, q_data.cnt <= 3'(mtd_pkg::MAX_RESULTS))

endmodule

/* sv/mtd_fifo.sv */
// ----------------------------------------------------------------------------
// mtd_fifo
// Short bundle queue between the decode front and the byte output back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mtd_fifo #(
  parameter int DEPTH = mtd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mtd_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output mtd_pkg::bundle_t pop_data,
  output logic             not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mtd_pkg::bundle_t   mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem[rd_ptr_r];

  // advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // store pushed bundles
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push, !full)
  `ASSERT_IMPLIES(a_no_underflow, clk, rst_n, pop, not_empty)

endmodule

/* sv/mtd_back.sv */
// ----------------------------------------------------------------------------
// mtd_back
// Takes bundles from the queue and sends their bytes one per cycle, unless
// out_ready stalls, through an output register, marking each bundle's last byte.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mtd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  mtd_pkg::bundle_t   q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output mtd_pkg::out_item_t out_data
);

  logic               cur_valid_r;
  mtd_pkg::bundle_t   cur_r;
  logic [1:0]         idx_r;
  logic               out_valid_r;
  mtd_pkg::out_item_t out_data_r;
  logic               adv;
  logic               fin;

  // move one byte when the output register is free
  assign adv   = cur_valid_r && (!out_valid_r || out_ready);
  assign fin   = adv && ({1'b0, idx_r} == cur_r.cnt - 3'd1);
  assign q_pop = q_valid && (!cur_valid_r || fin);

  // hold the current bundle and its byte index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (q_pop) begin
      cur_valid_r <= 1'b1;
      idx_r       <= 2'd0;
    end else if (fin) begin
      cur_valid_r <= 1'b0;
    end else if (adv) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.out_byte <= cur_r.bytes[idx_r];
      out_data_r.last     <= fin;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_IMPLIES(a_bundle_nonempty, clk, rst_n, cur_valid_r, cur_r.cnt != 3'd0)
  `ASSERT_IMPLIES(a_idx_in_range, clk, rst_n, cur_valid_r, {1'b0, idx_r} < cur_r.cnt)

endmodule

/* sv/mime_transfer_decoder.sv */
// ----------------------------------------------------------------------------
// mime_transfer_decoder
// Decodes a MIME body part byte stream: pass-through, quoted-printable or
// base64, with CR-before-LF removal and a flush command at end of part.
//
//   channel  dir  handshake              payload
//   cfg      in   cfg_valid/cfg_ready    cfg_data (decode mode, 2 bits)
//   in       in   in_valid/in_ready      in_data  {cmd, in_byte}
//   out      out  out_valid/out_ready    out_data {out_byte, last}
//
// The front takes one input item per cycle while the queue is not full and
// decodes it in that cycle into a bundle of zero to four bytes. Bundles wait
// in a QUEUE_DEPTH-entry queue; the back sends one byte per cycle unless
// out_ready stalls it. in_ready drops only while the queue is full.
// Reset is synchronous and clears all control state.
// ----------------------------------------------------------------------------
module mime_transfer_decoder #(
  parameter int QUEUE_DEPTH = mtd_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  mtd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mtd_pkg::out_item_t out_data
);

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_not_empty;
  mtd_pkg::bundle_t q_wdata;
  mtd_pkg::bundle_t q_rdata;

  // decode front
  mtd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  // bundle queue
  mtd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .not_empty (q_not_empty)
  );

  // byte output back
  mtd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
